FILE: design/q_table_learning_update_top_defines.svh
// Assertion macros shared by the q-table learning update design.
`ifndef Q_TABLE_LEARNING_UPDATE_TOP_DEFINES_SVH
`define Q_TABLE_LEARNING_UPDATE_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is high.
`define QLU_ASSERT_IMPLY(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("q-table update: implication check failed");
// Next-cycle implication, disabled while reset is high.
`define QLU_ASSERT_NEXT(name, clk, rst, cond, expr) \
   name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("q-table update: next-cycle check failed");
`else
`define QLU_ASSERT_IMPLY(name, clk, rst, cond, expr)
`define QLU_ASSERT_NEXT(name, clk, rst, cond, expr)
`endif
`endif

FILE: design/qlu_pkg.sv
// Types, constants and helper functions of the q-table learning update block.
`default_nettype none
package qlu_pkg;

   localparam int unsigned QLU_STATE_COUNT  = 64;
   localparam int unsigned QLU_ACTION_COUNT = 8;

   localparam int unsigned VAL_W       = 32;
   localparam int unsigned RATE_W      = 17;
   localparam int unsigned FRAC_W      = 16;
   localparam int unsigned PROD_W      = 50;
   localparam int unsigned SUM_W       = 52;
   localparam int unsigned STATE_IN_W  = 6;
   localparam int unsigned ACTION_IN_W = 3;
   localparam int unsigned CMD_W       = 3;
   localparam int unsigned CSR_IDX_W   = 2;

   localparam logic [RATE_W-1:0] RATE_ONE          = 17'h10000;
   localparam logic [RATE_W-1:0] LEARN_RATE_RESET  = 17'd3277;
   localparam logic [RATE_W-1:0] DISCOUNT_RESET    = 17'd58982;
   localparam logic signed [SUM_W-1:0] ROUND_HALF  = 52'sd32768;

   typedef enum logic [CMD_W-1:0] {
      CMD_LEARN    = 3'd0,
      CMD_TERMINAL = 3'd1,
      CMD_SET      = 3'd2,
      CMD_INIT     = 3'd3,
      CMD_READ     = 3'd4,
      CMD_BEST     = 3'd5
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEARN_RATE = 2'd0,
      CSR_DISCOUNT   = 2'd1
   } csr_index_type;

   typedef struct packed {
      logic signed [VAL_W-1:0] value;
      logic signed [VAL_W-1:0] change;
      logic        [VAL_W-1:0] visits;
   } entry_type;

   typedef struct packed {
      logic        [CMD_W-1:0]       cmd;
      logic        [STATE_IN_W-1:0]  state_index;
      logic        [ACTION_IN_W-1:0] action_index;
      logic signed [VAL_W-1:0]       reward;
      logic        [STATE_IN_W-1:0]  next_state;
      logic signed [VAL_W-1:0]       new_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [VAL_W-1:0]       value_out;
      logic signed [VAL_W-1:0]       delta_out;
      logic        [VAL_W-1:0]       visit_count;
      logic        [ACTION_IN_W-1:0] best_action;
      logic        [VAL_W-1:0]       update_total;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [RATE_W-1:0]    data;
   } csr_payload_type;

   // Saturate a wide signed value to 32 bits.
   function automatic logic signed [VAL_W-1:0] sat_value(input logic signed [SUM_W-1:0] x);
      logic signed [VAL_W-1:0] result;
      if ((&x[SUM_W-1:VAL_W-1]) || !(|x[SUM_W-1:VAL_W-1])) begin
         result = x[VAL_W-1:0];
      end else if (x[SUM_W-1]) begin
         result = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         result = {1'b0, {(VAL_W-1){1'b1}}};
      end
      return result;
   endfunction

   function automatic logic [VAL_W-1:0] sat_inc(input logic [VAL_W-1:0] v);
      return (&v) ? v : v + 32'd1;
   endfunction

   function automatic logic [RATE_W-1:0] clamp_rate(input logic [RATE_W-1:0] r);
      return (r > RATE_ONE) ? RATE_ONE : r;
   endfunction

   function automatic logic signed [SUM_W-1:0] widen_prod(input logic signed [PROD_W-1:0] p);
      return {{(SUM_W-PROD_W){p[PROD_W-1]}}, p};
   endfunction

   function automatic logic signed [SUM_W-1:0] widen_value(input logic signed [VAL_W-1:0] v);
      return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
   endfunction

   // Index reduced modulo a constant, built as a constant table over all raw codes.
   function automatic int unsigned wrap_index(input int unsigned raw,
                                              input int unsigned modulus,
                                              input int unsigned span);
      int unsigned r;
      int unsigned result;
      r = 0;
      result = 0;
      for (int unsigned i = 0; i < span; i++) begin
         if (i == raw) begin
            result = r;
         end
         r = (r + 1 == modulus) ? 0 : r + 1;
      end
      return result;
   endfunction

endpackage
`default_nettype wire

FILE: design/qlu_stream_if.sv
// Valid/ready channel interface carrying one payload per transaction.
`default_nettype none
interface qlu_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

FILE: design/qlu_entry_ram.sv
// Entry table memory: one write port, one registered read port.
`default_nettype none
module qlu_entry_ram
   import qlu_pkg::*;
#(
   parameter int unsigned DEPTH  = QLU_STATE_COUNT * QLU_ACTION_COUNT,
   parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  entry_type         wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: design/q_table_learning_update_top.sv
// Top level of the tabular q-learning update engine.
//
// Channels: req_chan takes one command per transaction, rsp_chan returns exactly
// one result transaction per command, csr_chan writes learn_rate (index 0) or
// discount (index 1); csr_chan is always ready, and other indexes are ignored.
// All entries live in a single synchronous memory (value, last change, visits).
// The argmax scan of a learn or best-action command issues one memory read per
// action; a learn also uses the one shared 18x32 multiplier three times and then
// does the read-modify-write of the entry.
// After reset the block first writes zeros to all STATE_COUNT*ACTION_COUNT
// entries, one per cycle, and takes no command until that pass is done; the
// rate registers return to 3277 and 58982 and the update total to zero.
// The result sits in an output register: while the receiver stalls, one more
// command can be accepted and worked on, and it waits until the register frees.
`default_nettype none
`include "q_table_learning_update_top_defines.svh"
module q_table_learning_update_top
   import qlu_pkg::*;
#(
   parameter int unsigned STATE_COUNT  = QLU_STATE_COUNT,
   parameter int unsigned ACTION_COUNT = QLU_ACTION_COUNT
) (
   input logic           clock,
   input logic           reset,
   qlu_stream_if.sink    req_chan,
   qlu_stream_if.source  rsp_chan,
   qlu_stream_if.sink    csr_chan
);

   localparam int unsigned ENTRY_COUNT = STATE_COUNT * ACTION_COUNT;
   localparam int unsigned ADDR_W      = $clog2(ENTRY_COUNT);
   localparam int unsigned ACT_W       = $clog2(ACTION_COUNT);
   localparam int unsigned SCAN_W      = $clog2(ACTION_COUNT + 1);
   localparam int unsigned STATE_SPAN  = 2 ** STATE_IN_W;
   localparam int unsigned ACTION_SPAN = 2 ** ACTION_IN_W;

   typedef enum logic [10:0] {
      ST_CLEAR  = 11'b000_0000_0001,
      ST_IDLE   = 11'b000_0000_0010,
      ST_SCAN   = 11'b000_0000_0100,
      ST_SCALE  = 11'b000_0000_1000,
      ST_TARGET = 11'b000_0001_0000,
      ST_FETCH  = 11'b000_0010_0000,
      ST_LOAD   = 11'b000_0100_0000,
      ST_MIX    = 11'b000_1000_0000,
      ST_SUM    = 11'b001_0000_0000,
      ST_WRITE  = 11'b010_0000_0000,
      ST_RESP   = 11'b100_0000_0000
   } fsm_state_type;

   // Control registers.
   fsm_state_type        state_ff, state_in;
   logic [ADDR_W-1:0]    clr_cnt_ff, clr_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [VAL_W-1:0]     total_ff, total_in;
   logic [RATE_W-1:0]    learn_rate_ff, learn_rate_in;
   logic [RATE_W-1:0]    discount_ff, discount_in;

   // Command and datapath registers.
   cmd_type                  cmd_ff, cmd_in;
   logic [ADDR_W-1:0]        entry_ff, entry_in;
   logic [ADDR_W-1:0]        scan_base_ff, scan_base_in;
   logic [SCAN_W-1:0]        scan_cnt_ff, scan_cnt_in;
   logic [ACT_W-1:0]         best_idx_ff, best_idx_in;
   entry_type                best_word_ff, best_word_in;
   logic signed [VAL_W-1:0]  new_value_ff, new_value_in;
   logic signed [VAL_W-1:0]  target_ff, target_in;
   logic signed [PROD_W-1:0] mul_ff, mul_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   entry_type                old_word_ff, old_word_in;
   logic signed [VAL_W-1:0]  upd_val_ff, upd_val_in;
   entry_type                res_word_ff, res_word_in;
   rsp_payload_type          rsp_payload_ff, rsp_payload_in;

   // Memory port.
   logic              mem_wr_en;
   logic [ADDR_W-1:0] mem_wr_addr;
   entry_type         mem_wr_data;
   logic [ADDR_W-1:0] mem_rd_addr;
   entry_type         mem_rd_data;

   // Index decode of the incoming command.
   logic [ADDR_W-1:0] st_mod, nx_mod, act_mod;
   logic [ADDR_W-1:0] scan_off;

   // Shared multiplier and fixed-point arithmetic.
   logic [RATE_W-1:0]        alpha, gamma, mul_a;
   logic signed [VAL_W-1:0]  mul_b;
   logic signed [SUM_W-1:0]  scaled_sum, target_sum, blend_sum, diff_sum;

   logic req_fire, rsp_fire, csr_fire;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign csr_fire = csr_chan.valid && csr_chan.ready;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

   // Out-of-range indexes wrap modulo the table dimensions.
   assign st_mod  = ADDR_W'(wrap_index(32'(req_chan.payload.state_index), STATE_COUNT,
                                       STATE_SPAN));
   assign nx_mod  = ADDR_W'(wrap_index(32'(req_chan.payload.next_state), STATE_COUNT,
                                       STATE_SPAN));
   assign act_mod = ADDR_W'(wrap_index(32'(req_chan.payload.action_index), ACTION_COUNT,
                                       ACTION_SPAN));

   // The scan counter runs one past the last action to retire the final read.
   assign scan_off    = (scan_cnt_ff < SCAN_W'(ACTION_COUNT)) ? ADDR_W'(scan_cnt_ff) : '0;
   assign mem_rd_addr = (state_ff == ST_SCAN) ? scan_base_ff + scan_off : entry_ff;

   assign alpha = clamp_rate(learn_rate_ff);
   assign gamma = clamp_rate(discount_ff);

   // One multiplier serves gamma*next, (1-alpha)*old and alpha*target in turn.
   assign mul_a = (state_ff == ST_SCALE) ? gamma :
                  (state_ff == ST_LOAD)  ? RATE_ONE - alpha : alpha;
   assign mul_b = (state_ff == ST_SCALE) ? best_word_ff.value :
                  (state_ff == ST_LOAD)  ? mem_rd_data.value : target_ff;
   assign mul_in = $signed({1'b0, mul_a}) * mul_b;

   // Rounded floor division by 65536, then saturation where the values are stored.
   assign scaled_sum = (widen_prod(mul_ff) + ROUND_HALF) >>> FRAC_W;
   assign target_sum = widen_value(new_value_ff) + scaled_sum;
   assign blend_sum  = (widen_prod(acc_ff) + widen_prod(mul_ff) + ROUND_HALF) >>> FRAC_W;
   assign diff_sum   = widen_value(upd_val_ff) - widen_value(old_word_ff.value);

   always_comb begin
      cmd_type   req_cmd;
      logic      take;
      entry_type upd_word;

      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_fire;
      total_in      = total_ff;
      learn_rate_in = learn_rate_ff;
      discount_in   = discount_ff;
      cmd_in        = cmd_ff;
      entry_in      = entry_ff;
      scan_base_in  = scan_base_ff;
      scan_cnt_in   = scan_cnt_ff;
      best_idx_in   = best_idx_ff;
      best_word_in  = best_word_ff;
      new_value_in  = new_value_ff;
      target_in     = target_ff;
      acc_in        = acc_ff;
      old_word_in   = old_word_ff;
      upd_val_in    = upd_val_ff;
      res_word_in   = res_word_ff;
      rsp_payload_in = rsp_payload_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = entry_ff;
      mem_wr_data   = '0;

      req_cmd = cmd_type'(req_chan.payload.cmd);
      take    = (scan_cnt_ff == SCAN_W'(1)) || (mem_rd_data.value > best_word_ff.value);

      upd_word.value  = upd_val_ff;
      upd_word.change = sat_value(diff_sum);
      upd_word.visits = sat_inc(old_word_ff.visits);

      if (csr_fire) begin
         unique case (csr_index_type'(csr_chan.payload.index))
            CSR_LEARN_RATE: learn_rate_in = csr_chan.payload.data;
            CSR_DISCOUNT:   discount_in   = csr_chan.payload.data;
            default: begin
            end
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_cnt_ff;
            if (clr_cnt_ff == ADDR_W'(ENTRY_COUNT - 1)) begin
               state_in = ST_IDLE;
            end else begin
               clr_cnt_in = clr_cnt_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in       = req_cmd;
               entry_in     = st_mod * ADDR_W'(ACTION_COUNT) + act_mod;
               new_value_in = req_chan.payload.new_value;
               // A terminal learn blends toward the reward alone.
               target_in    = req_chan.payload.reward;
               scan_cnt_in  = '0;
               best_idx_in  = '0;
               unique case (req_cmd)
                  CMD_LEARN: begin
                     // The reward rides in new_value_ff until the target is formed.
                     new_value_in = req_chan.payload.reward;
                     scan_base_in = nx_mod * ADDR_W'(ACTION_COUNT);
                     state_in     = ST_SCAN;
                  end
                  CMD_BEST: begin
                     scan_base_in = st_mod * ADDR_W'(ACTION_COUNT);
                     state_in     = ST_SCAN;
                  end
                  CMD_TERMINAL, CMD_SET, CMD_READ: state_in = ST_FETCH;
                  CMD_INIT: state_in = ST_WRITE;
                  default: begin
                     res_word_in = '0;
                     state_in    = ST_RESP;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            // Strictly greater keeps ties on the lowest action.
            if (scan_cnt_ff != '0 && take) begin
               best_word_in = mem_rd_data;
               best_idx_in  = ACT_W'(scan_cnt_ff - 1'b1);
            end
            if (scan_cnt_ff == SCAN_W'(ACTION_COUNT)) begin
               if (cmd_ff == CMD_LEARN) begin
                  state_in = ST_SCALE;
               end else begin
                  res_word_in = best_word_in;
                  state_in    = ST_RESP;
               end
            end else begin
               scan_cnt_in = scan_cnt_ff + 1'b1;
            end
         end
         ST_SCALE: begin
            state_in = ST_TARGET;
         end
         ST_TARGET: begin
            target_in = sat_value(target_sum);
            state_in  = ST_LOAD;
         end
         ST_FETCH: begin
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            old_word_in = mem_rd_data;
            unique case (cmd_ff)
               CMD_SET: begin
                  upd_val_in = new_value_ff;
                  state_in   = ST_WRITE;
               end
               CMD_READ: begin
                  res_word_in = mem_rd_data;
                  state_in    = ST_RESP;
               end
               CMD_LEARN, CMD_TERMINAL: state_in = ST_MIX;
               default: state_in = ST_RESP;
            endcase
         end
         ST_MIX: begin
            acc_in   = mul_ff;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            upd_val_in = sat_value(blend_sum);
            state_in   = ST_WRITE;
         end
         ST_WRITE: begin
            mem_wr_en = 1'b1;
            if (cmd_ff == CMD_INIT) begin
               mem_wr_data.value  = new_value_ff;
               mem_wr_data.change = '0;
               mem_wr_data.visits = '0;
            end else begin
               mem_wr_data = upd_word;
               total_in    = sat_inc(total_ff);
            end
            res_word_in = mem_wr_data;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in                = 1'b1;
               rsp_payload_in.value_out    = res_word_ff.value;
               rsp_payload_in.delta_out    = res_word_ff.change;
               rsp_payload_in.visit_count  = res_word_ff.visits;
               rsp_payload_in.best_action  = ACTION_IN_W'(best_idx_ff);
               rsp_payload_in.update_total = total_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_cnt_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         total_ff      <= '0;
         learn_rate_ff <= LEARN_RATE_RESET;
         discount_ff   <= DISCOUNT_RESET;
      end else begin
         state_ff      <= state_in;
         clr_cnt_ff    <= clr_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         total_ff      <= total_in;
         learn_rate_ff <= learn_rate_in;
         discount_ff   <= discount_in;
      end
      cmd_ff         <= cmd_in;
      entry_ff       <= entry_in;
      scan_base_ff   <= scan_base_in;
      scan_cnt_ff    <= scan_cnt_in;
      best_idx_ff    <= best_idx_in;
      best_word_ff   <= best_word_in;
      new_value_ff   <= new_value_in;
      target_ff      <= target_in;
      acc_ff         <= acc_in;
      old_word_ff    <= old_word_in;
      upd_val_ff     <= upd_val_in;
      res_word_ff    <= res_word_in;
      rsp_payload_ff <= rsp_payload_in;
      // The product register loads only where the datapath consumes it.
      if (state_ff == ST_SCALE || state_ff == ST_LOAD || state_ff == ST_MIX) begin
         mul_ff <= mul_in;
      end
   end

   qlu_entry_ram #(
      .DEPTH  (ENTRY_COUNT),
      .ADDR_W (ADDR_W)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The table is written only by the clearing pass and the write-back step.
   `QLU_ASSERT_IMPLY(a_write_phase, clock, reset, mem_wr_en, (state_ff == ST_CLEAR) || (state_ff == ST_WRITE))
   // The update total never goes backward.
   `QLU_ASSERT_NEXT(a_total_monotonic, clock, reset, 1'b1, total_ff >= $past(total_ff))
   // The argmax found by the scan is a real action of the table.
   `QLU_ASSERT_IMPLY(a_best_in_range, clock, reset, state_ff == ST_SCALE, SCAN_W'(best_idx_ff) < SCAN_W'(ACTION_COUNT))

endmodule
`default_nettype wire
